FILE: rtl/sspq_pkg.sv
// ----------------------------------------------------------------------------
// sspq_pkg: shared types and constants of the stable sorted priority queue
// Opcodes, result codes, beat structs and cell control for the cell chain.
// ----------------------------------------------------------------------------
package sspq_pkg;

  // default sizes
  localparam int unsigned DefDepth   = 16;
  localparam int unsigned DefKeyBits = 16;
  localparam int unsigned DefIdBits  = 16;

  // field widths of the beats
  localparam int unsigned FieldBits = 16;

  // request codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_LIST   = 2'd2
  } opcode_e;

  // result codes
  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_POPPED   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_LIST     = 3'd4
  } status_e;

  // what every cell does in one cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  // per-cell control
  typedef struct packed {
    cell_op_e op;
    logic     occ;   // cell holds a live entry
    logic     wrap;  // cell is the last live entry
  } cell_ctrl_t;

  // input beat
  typedef struct packed {
    logic [1:0]           opcode;
    logic [FieldBits-1:0] plane_id;
    logic [FieldBits-1:0] wait_key;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [2:0]           status;
    logic [FieldBits-1:0] entry_id;
    logic [FieldBits-1:0] entry_key;
    logic                 last;
  } out_beat_t;

endpackage

FILE: rtl/sspq_cell.sv
// ----------------------------------------------------------------------------
// sspq_cell: one slot of the sorted cell chain
// Holds one key and id; inserts, shifts toward the head or rotates.
// ----------------------------------------------------------------------------
module sspq_cell #(
  parameter int unsigned KEY_BITS = sspq_pkg::DefKeyBits,
  parameter int unsigned ID_BITS  = sspq_pkg::DefIdBits
) (
  input  logic                clk_i,
  input  sspq_pkg::cell_ctrl_t ctrl_i,
  input  logic [KEY_BITS-1:0] new_key_i,
  input  logic [ID_BITS-1:0]  new_id_i,
  input  logic                left_c_i,
  input  logic [KEY_BITS-1:0] left_key_i,
  input  logic [ID_BITS-1:0]  left_id_i,
  input  logic [KEY_BITS-1:0] right_key_i,
  input  logic [ID_BITS-1:0]  right_id_i,
  input  logic [KEY_BITS-1:0] head_key_i,
  input  logic [ID_BITS-1:0]  head_id_i,
  output logic                c_o,
  output logic [KEY_BITS-1:0] key_o,
  output logic [ID_BITS-1:0]  id_o
);
  import sspq_pkg::*;

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [ID_BITS-1:0]  id_q, id_d;

  // new entry goes here or further toward the head
  assign c_o = !ctrl_i.occ || (key_q > new_key_i);

  // next slot contents
  always_comb begin
    key_d = key_q;
    id_d  = id_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (c_o) begin
          if (left_c_i) begin
            key_d = left_key_i;
            id_d  = left_id_i;
          end else begin
            key_d = new_key_i;
            id_d  = new_id_i;
          end
        end
      end
      CELL_POP: begin
        key_d = right_key_i;
        id_d  = right_id_i;
      end
      CELL_ROTATE: begin
        if (ctrl_i.wrap) begin
          key_d = head_key_i;
          id_d  = head_id_i;
        end else begin
          key_d = right_key_i;
          id_d  = right_id_i;
        end
      end
      default: begin
        key_d = key_q;
        id_d  = id_q;
      end
    endcase
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    id_q  <= id_d;
  end

  assign key_o = key_q;
  assign id_o  = id_q;

endmodule

FILE: rtl/sspq_chain.sv
// ----------------------------------------------------------------------------
// sspq_chain: row of sorted cells
// Wires the cells to their neighbors and derives per-cell control from count.
// ----------------------------------------------------------------------------
module sspq_chain #(
  parameter int unsigned DEPTH    = sspq_pkg::DefDepth,
  parameter int unsigned KEY_BITS = sspq_pkg::DefKeyBits,
  parameter int unsigned ID_BITS  = sspq_pkg::DefIdBits,
  localparam int unsigned CntBits = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  sspq_pkg::cell_op_e  op_i,
  input  logic [CntBits-1:0]  count_i,
  input  logic [KEY_BITS-1:0] new_key_i,
  input  logic [ID_BITS-1:0]  new_id_i,
  output logic [KEY_BITS-1:0] head_key_o,
  output logic [ID_BITS-1:0]  head_id_o
);
  import sspq_pkg::*;

  logic [KEY_BITS-1:0] key_w [DEPTH];
  logic [ID_BITS-1:0]  id_w  [DEPTH];
  logic [DEPTH-1:0]    c_w;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t          ctrl;
    logic                left_c;
    logic [KEY_BITS-1:0] left_key, right_key;
    logic [ID_BITS-1:0]  left_id, right_id;

    // per-cell control from the live count
    assign ctrl.op   = op_i;
    assign ctrl.occ  = CntBits'(i) < count_i;
    assign ctrl.wrap = CntBits'(i + 1) == count_i;

    // neighbor links
    if (i == 0) begin : g_head
      assign left_c   = 1'b0;
      assign left_key = new_key_i;
      assign left_id  = new_id_i;
    end else begin : g_mid
      assign left_c   = c_w[i-1];
      assign left_key = key_w[i-1];
      assign left_id  = id_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_key = key_w[i];
      assign right_id  = id_w[i];
    end else begin : g_inner
      assign right_key = key_w[i+1];
      assign right_id  = id_w[i+1];
    end

    sspq_cell #(
      .KEY_BITS (KEY_BITS),
      .ID_BITS  (ID_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_key_i   (new_key_i),
      .new_id_i    (new_id_i),
      .left_c_i    (left_c),
      .left_key_i  (left_key),
      .left_id_i   (left_id),
      .right_key_i (right_key),
      .right_id_i  (right_id),
      .head_key_i  (key_w[0]),
      .head_id_i   (id_w[0]),
      .c_o         (c_w[i]),
      .key_o       (key_w[i]),
      .id_o        (id_w[i])
    );
  end

  assign head_key_o = key_w[0];
  assign head_id_o  = id_w[0];

endmodule

FILE: rtl/stable_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue: min-first sorted list in a chain of cells
//
//   channel | direction | beat       | handshake
//   --------+-----------+------------+-------------------------------
//   in      | input     | in_beat_t  | in_valid_i / in_stall_o
//   out     | output    | out_beat_t | out_valid_o / out_stall_i
//
// Insert, pop and an ignored opcode are each done with when taken; the cells shift in place.
// A list of n entries gives n beats: the chain rotates by one cell per beat
// and is back in order after the last one; no request is taken meanwhile.
// Reset clears the count and the control; cell contents are not reset.
// A stalled result holds the output register; a new request waits for it.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue #(
  parameter int unsigned DEPTH    = sspq_pkg::DefDepth,
  parameter int unsigned KEY_BITS = sspq_pkg::DefKeyBits,
  parameter int unsigned ID_BITS  = sspq_pkg::DefIdBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sspq_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sspq_pkg::out_beat_t out_data_o
);
  import sspq_pkg::*;

  localparam int unsigned CntBits = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [CntBits-1:0] rem_q, rem_d;
  logic               out_valid_q, out_valid_d;
  out_beat_t          out_q, out_d;
  cell_op_e           chain_op;

  logic                in_fire, out_free, full, empty;
  logic [KEY_BITS-1:0] new_key, head_key;
  logic [ID_BITS-1:0]  new_id, head_id;

  logic [KEY_BITS+FieldBits-1:0] key_in_ext, key_out_ext;
  logic [ID_BITS+FieldBits-1:0]  id_in_ext, id_out_ext;

  // fit fields to the storage widths and back
  assign key_in_ext  = {{KEY_BITS{1'b0}}, in_data_i.wait_key};
  assign id_in_ext   = {{ID_BITS{1'b0}}, in_data_i.plane_id};
  assign new_key     = key_in_ext[KEY_BITS-1:0];
  assign new_id      = id_in_ext[ID_BITS-1:0];
  assign key_out_ext = {{FieldBits{1'b0}}, head_key};
  assign id_out_ext  = {{FieldBits{1'b0}}, head_id};

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign full       = cnt_q == CntBits'(DEPTH);
  assign empty      = cnt_q == '0;

  // request decode and list sequencing
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    chain_op    = CELL_HOLD;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_d      = '0;
          out_d.last = 1'b1;
          case (in_data_i.opcode)
            OP_INSERT: begin
              out_valid_d = 1'b1;
              if (full) begin
                out_d.status = ST_FULL;
              end else begin
                out_d.status = ST_INSERTED;
                chain_op     = CELL_INSERT;
                cnt_d        = cnt_q + 1'b1;
              end
            end
            OP_POP: begin
              out_valid_d = 1'b1;
              if (empty) begin
                out_d.status = ST_EMPTY;
              end else begin
                out_d.status    = ST_POPPED;
                out_d.entry_id  = id_out_ext[FieldBits-1:0];
                out_d.entry_key = key_out_ext[FieldBits-1:0];
                chain_op        = CELL_POP;
                cnt_d           = cnt_q - 1'b1;
              end
            end
            OP_LIST: begin
              out_valid_d = 1'b1;
              if (empty) begin
                out_d.status = ST_EMPTY;
              end else begin
                out_d.status    = ST_LIST;
                out_d.entry_id  = id_out_ext[FieldBits-1:0];
                out_d.entry_key = key_out_ext[FieldBits-1:0];
                out_d.last      = cnt_q == CntBits'(1);
                chain_op        = CELL_ROTATE;
                rem_d           = cnt_q - 1'b1;
                if (cnt_q != CntBits'(1)) begin
                  state_d = S_LIST;
                end
              end
            end
            default: begin
              out_d = out_q;
            end
          endcase
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.status    = ST_LIST;
          out_d.entry_id  = id_out_ext[FieldBits-1:0];
          out_d.entry_key = key_out_ext[FieldBits-1:0];
          out_d.last      = rem_q == CntBits'(1);
          chain_op        = CELL_ROTATE;
          rem_d           = rem_q - 1'b1;
          if (rem_q == CntBits'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // sorted cell chain
  sspq_chain #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .ID_BITS  (ID_BITS)
  ) u_chain (
    .clk_i      (clk_i),
    .op_i       (chain_op),
    .count_i    (cnt_q),
    .new_key_i  (new_key),
    .new_id_i   (new_id),
    .head_key_o (head_key),
    .head_id_o  (head_id)
  );

  // count never exceeds the chain length
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(DEPTH))
    else $error("entry count beyond depth");

  // a list in progress always has beats left
  a_rem_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |-> (rem_q != '0))
    else $error("list walk with nothing left");

  // a pop on a non-empty queue removes exactly one entry
  a_pop_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.opcode == OP_POP && !empty) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("pop did not remove one entry");

  // a dropped insert leaves the count alone
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.opcode == OP_INSERT && full) |=> $stable(cnt_q))
    else $error("insert into full queue changed count");

  // the count is frozen while listing
  a_list_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |=> $stable(cnt_q))
    else $error("count changed during list");

endmodule

FILE: verif/tb_stable_sorted_priority_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stable_sorted_priority_queue: self-checking bench for the sorted queue
// Sends insert, pop, list and unused requests with random idling on both
// channels. Every result beat is checked against a shadow sorted list.
// ----------------------------------------------------------------------------
module tb_stable_sorted_priority_queue;
  import sspq_pkg::*;

  localparam int          ClkPeriod     = 4;
  localparam int          ResetCycles   = 7;
  localparam int          QDepth        = DefDepth;
  localparam int          RandomItems   = 320;
  localparam int          IdlePct       = 25;
  localparam int          TailCycles    = 40;
  localparam int          TimeoutCycles = 200000;
  localparam logic [1:0]  OpUnused      = 2'd3;

  // one queued request plus a flag to hold it until the block has drained
  typedef struct packed {
    logic     wait_drain;
    in_beat_t beat;
  } req_item_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_data_o;

  // stimulus feed and awaited result beats
  req_item_t request_feed[$];
  req_item_t req_next;
  out_beat_t replies_due[$];
  out_beat_t beat_due;

  // shadow copy of the sorted list
  logic [FieldBits-1:0] shadow_keys[QDepth];
  logic [FieldBits-1:0] shadow_ids[QDepth];
  int                   shadow_count = 0;

  // bookkeeping
  int  accepted_cnt = 0;
  int  error_cnt    = 0;
  int  beats_seen   = 0;
  int  n_insert     = 0;
  int  n_dropped    = 0;
  int  n_popped     = 0;
  int  n_empty      = 0;
  int  n_list_beats = 0;
  int  n_ignored    = 0;
  logic calm;

  // no idling on either side over a long stretch of the run
  assign calm = (accepted_cnt >= 120) && (accepted_cnt < 210);

  stable_sorted_priority_queue u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_cnt++;
  endtask

  task automatic compare_field(input string name, input logic [FieldBits-1:0] got,
                               input logic [FieldBits-1:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    end
  endtask

  // apply one accepted request to the shadow list and queue its result beats
  function automatic void apply_to_shadow_queue(in_beat_t req);
    out_beat_t rsp;
    int        slot;
    rsp      = '0;
    rsp.last = 1'b1;
    case (req.opcode)
      OP_INSERT: begin
        if (shadow_count >= QDepth) begin
          rsp.status = ST_FULL;
          n_dropped++;
        end else begin
          // goes behind every entry whose key is not greater
          slot = shadow_count;
          for (int i = shadow_count - 1; i >= 0 && shadow_keys[i] > req.wait_key; i--) begin
            slot = i;
          end
          for (int i = shadow_count; i > slot; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_ids[i]  = shadow_ids[i-1];
          end
          shadow_keys[slot] = req.wait_key;
          shadow_ids[slot]  = req.plane_id;
          shadow_count++;
          rsp.status = ST_INSERTED;
          n_insert++;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          rsp.status = ST_EMPTY;
          n_empty++;
        end else begin
          rsp.status    = ST_POPPED;
          rsp.entry_id  = shadow_ids[0];
          rsp.entry_key = shadow_keys[0];
          for (int i = 1; i < shadow_count; i++) begin
            shadow_keys[i-1] = shadow_keys[i];
            shadow_ids[i-1]  = shadow_ids[i];
          end
          shadow_count--;
          n_popped++;
        end
      end
      OP_LIST: begin
        if (shadow_count == 0) begin
          rsp.status = ST_EMPTY;
          n_empty++;
        end else begin
          // one beat per entry, front to back
          for (int i = 0; i < shadow_count; i++) begin
            rsp.status    = ST_LIST;
            rsp.entry_id  = shadow_ids[i];
            rsp.entry_key = shadow_keys[i];
            rsp.last      = (i == shadow_count - 1);
            replies_due.push_back(rsp);
            n_list_beats++;
          end
          return;
        end
      end
      default: begin
        // unused opcode, no beat and no state change
        n_ignored++;
        return;
      end
    endcase
    replies_due.push_back(rsp);
  endfunction

  task automatic push_req(input logic [1:0] op, input logic [FieldBits-1:0] id,
                          input logic [FieldBits-1:0] key, input logic drain);
    req_item_t item;
    item.wait_drain     = drain;
    item.beat.opcode    = op;
    item.beat.plane_id  = id;
    item.beat.wait_key  = key;
    request_feed.push_back(item);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        apply_to_shadow_queue(in_data_i);
        accepted_cnt <= accepted_cnt + 1;
      end
      // present the next beat once the current one is gone
      if (!in_valid_i || !in_stall_o) begin
        if (request_feed.size() > 0 &&
            !(!calm && $urandom_range(99) < IdlePct) &&
            !(request_feed[0].wait_drain && replies_due.size() > 0)) begin
          req_next = request_feed.pop_front();
          in_valid_i <= 1'b1;
          in_data_i  <= req_next.beat;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and random stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        beats_seen++;
        if (replies_due.size() == 0) begin
          flag_mismatch($sformatf("result beat with nothing awaited: %p", out_data_o));
        end else begin
          beat_due = replies_due.pop_front();
          compare_field("status", FieldBits'(out_data_o.status), FieldBits'(beat_due.status));
          compare_field("entry_id", out_data_o.entry_id, beat_due.entry_id);
          compare_field("entry_key", out_data_o.entry_key, beat_due.entry_key);
          compare_field("last", FieldBits'(out_data_o.last), FieldBits'(beat_due.last));
        end
      end
      out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
    end
  end

  // stimulus, end of run and verdict
  initial begin
    int                   pick;
    logic                 fill_phase;
    logic [1:0]           op;
    logic [FieldBits-1:0] key;

    // empty queue cases and the unused opcode
    push_req(OP_POP, 16'h0000, 16'h0000, 1'b0);
    push_req(OP_LIST, 16'hFFFF, 16'hFFFF, 1'b0);
    push_req(OpUnused, 16'hA5A5, 16'h5A5A, 1'b0);
    // field extremes and equal keys keeping arrival order
    push_req(OP_INSERT, 16'hFFFF, 16'hFFFF, 1'b0);
    push_req(OP_INSERT, 16'h0000, 16'h0000, 1'b0);
    push_req(OP_INSERT, 16'h1111, 16'hFFFF, 1'b0);
    push_req(OP_INSERT, 16'h2222, 16'h0000, 1'b0);
    push_req(OP_LIST, 16'h0000, 16'h0000, 1'b0);
    push_req(OP_POP, 16'h0000, 16'h0000, 1'b0);
    // fill up with repeated keys, overflow, then a full-length list
    for (int i = 0; i < QDepth - 3; i++) begin
      push_req(OP_INSERT, FieldBits'(16'h0100 + i), {i[1:0], 14'h0}, 1'b0);
    end
    push_req(OP_INSERT, 16'hDEAD, 16'h0001, 1'b0);
    push_req(OP_LIST, 16'h0000, 16'h0000, 1'b0);

    // random part, alternating fill-heavy and drain-heavy phases
    for (int n = 0; n < RandomItems; n++) begin
      fill_phase = ((n / 40) % 2) == 0;
      pick = $urandom_range(99);
      if (pick < 5) begin
        op = OpUnused;
      end else if (pick < 15) begin
        op = OP_LIST;
      end else if (fill_phase ? (pick < 75) : (pick < 35)) begin
        op = OP_INSERT;
      end else begin
        op = OP_POP;
      end
      case ($urandom_range(3))
        0, 1: key = FieldBits'($urandom_range(7));
        2: key = FieldBits'($urandom);
        default: key = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
      push_req(op, FieldBits'($urandom), key, (n % 80) == 0);
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_feed.size() > 0 || in_valid_i) @(posedge clk_i);
    while (replies_due.size() > 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("run covered %0d inserts (%0d dropped on a full queue), %0d pops, %0d list beats",
             n_insert, n_dropped, n_popped, n_list_beats);
    $display("plus %0d empty replies and %0d unused opcodes; %0d result beats checked",
             n_empty, n_ignored, beats_seen);
    if (error_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", error_cnt);
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("timeout with %0d result beats still awaited", replies_due.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
